// File: design/stl_pkg.sv
// Package for the source token lexer: codes, types and byte classification helpers.
package stl_pkg;

	// Default counter widths
	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;

	// Output queue
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// Request op codes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Token kinds
	localparam logic [4:0] K_IF      = 5'd0;
	localparam logic [4:0] K_ELSE    = 5'd1;
	localparam logic [4:0] K_WHILE   = 5'd2;
	localparam logic [4:0] K_VAR     = 5'd3;
	localparam logic [4:0] K_DEF     = 5'd4;
	localparam logic [4:0] K_GE      = 5'd5;
	localparam logic [4:0] K_LE      = 5'd6;
	localparam logic [4:0] K_EQUAL   = 5'd7;
	localparam logic [4:0] K_GREATER = 5'd8;
	localparam logic [4:0] K_LESS    = 5'd9;
	localparam logic [4:0] K_MOD     = 5'd10;
	localparam logic [4:0] K_ASSIGN  = 5'd11;
	localparam logic [4:0] K_PLUS    = 5'd12;
	localparam logic [4:0] K_MINUS   = 5'd13;
	localparam logic [4:0] K_STAR    = 5'd14;
	localparam logic [4:0] K_SLASH   = 5'd15;
	localparam logic [4:0] K_SEMI    = 5'd16;
	localparam logic [4:0] K_LBRACE  = 5'd17;
	localparam logic [4:0] K_RBRACE  = 5'd18;
	localparam logic [4:0] K_LPAREN  = 5'd19;
	localparam logic [4:0] K_RPAREN  = 5'd20;
	localparam logic [4:0] K_COMMA   = 5'd21;
	localparam logic [4:0] K_INT     = 5'd22;
	localparam logic [4:0] K_FLOAT   = 5'd23;
	localparam logic [4:0] K_IDENT   = 5'd24;
	localparam logic [4:0] K_END     = 5'd25;
	localparam logic [4:0] K_UNKNOWN = 5'd26;

	// Characters
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_EQ   = 8'h3D;

	// Keyword spellings, packed big-endian
	localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
	localparam logic [39:0] KW_ELSE  = 40'h00_656C_7365;
	localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;
	localparam logic [39:0] KW_VAR   = 40'h00_0076_6172;
	localparam logic [39:0] KW_DEF   = 40'h00_0064_6566;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		P_NONE,
		P_INT,
		P_INTDOT,
		P_FLOAT,
		P_IDENT,
		P_LT,
		P_GT,
		P_EQ
	} pend_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
	} tok_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} fifo_ent_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha_u(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == 8'h5F);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B)
			|| (c == 8'h0C) || (c == 8'h0D);
	endfunction

	function automatic logic [4:0] single_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			8'h25:   k = K_MOD;
			8'h2B:   k = K_PLUS;
			8'h2D:   k = K_MINUS;
			8'h2A:   k = K_STAR;
			8'h2F:   k = K_SLASH;
			8'h3B:   k = K_SEMI;
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h2C:   k = K_COMMA;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] word_kind(input logic [15:0] len, input logic [39:0] pfx);
		logic [4:0] k;
		priority if (len == 16'd2 && pfx == KW_IF)    k = K_IF;
		else if (len == 16'd4 && pfx == KW_ELSE)      k = K_ELSE;
		else if (len == 16'd5 && pfx == KW_WHILE)     k = K_WHILE;
		else if (len == 16'd3 && pfx == KW_VAR)       k = K_VAR;
		else if (len == 16'd3 && pfx == KW_DEF)       k = K_DEF;
		else                                          k = K_IDENT;
		return k;
	endfunction

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [1:0] b);
		logic [16:0] s;
		s = {1'b0, a} + 17'(b);
		return s[16] ? LEN_MAX : s[15:0];
	endfunction

	function automatic logic [15:0] clamp16(input logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic tok_t make_tok(input logic [4:0] k, input logic [31:0] ln,
			input logic [31:0] col, input logic [15:0] len);
		tok_t t;
		t.kind   = k;
		t.line   = clamp16(ln);
		t.column = clamp16(col);
		t.length = len;
		return t;
	endfunction

endpackage

// File: design/source_token_lexer_top.sv
// Streaming lexer: one source byte per request in, tokens out through a small queue.
// Latency: a token enters the output queue at the edge that accepts the request
// completing it and is offered on the next cycle. Throughput: one request per cycle
// while the queue has room for three tokens; tokens drain one per cycle on tok_ready.
// Reset (arst_n low, asynchronous): no token pending, line and column zero, queue empty.
module source_token_lexer_top #(
	parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte requests
	input  logic        char_valid,
	output logic        char_ready,
	input  logic        op,
	input  logic [7:0]  character,
	// tokens
	output logic        tok_valid,
	input  logic        tok_ready,
	output logic [4:0]  kind,
	output logic [15:0] line,
	output logic [15:0] column,
	output logic [15:0] length,
	output logic        last_of_run
);

	localparam logic [32:0] COL_MAX33 = 33'((64'(1) << COLUMN_BITS) - 64'(1));

	// Scanner state
	stl_pkg::pend_t         pend_q, pend_d;
	logic [COLUMN_BITS-1:0] start_q, start_d;   // column of pending token start
	logic [15:0]            tlen_q, tlen_d;     // pending token length
	logic [39:0]            prefix_q, prefix_d; // first five bytes of an identifier
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;

	// Tokens produced by the current request
	stl_pkg::tok_t          res_c [stl_pkg::MAX_RES];
	logic [1:0]             n_res;
	logic                   handled;
	logic                   newline;
	logic                   do_flush;
	logic [32:0]            dot_sum;
	logic [31:0]            dot_col;
	logic [31:0]            line_x;

	// Output queue
	stl_pkg::fifo_ent_t        fifo_q [stl_pkg::FIFO_DEPTH];
	logic [stl_pkg::PTR_W-1:0] wr_q, rd_q;
	logic [stl_pkg::CNT_W-1:0] cnt_q;
	logic                      acc, pop;

	assign char_ready = cnt_q <= stl_pkg::CNT_W'(stl_pkg::FIFO_DEPTH - stl_pkg::MAX_RES);
	assign acc        = char_valid && char_ready;
	assign tok_valid  = cnt_q != '0;
	assign pop        = tok_valid && tok_ready;

	assign kind        = fifo_q[rd_q].tok.kind;
	assign line        = fifo_q[rd_q].tok.line;
	assign column      = fifo_q[rd_q].tok.column;
	assign length      = fifo_q[rd_q].tok.length;
	assign last_of_run = fifo_q[rd_q].last;

	// Next state and the tokens emitted for one request
	always_comb begin
		pend_d   = pend_q;
		start_d  = start_q;
		tlen_d   = tlen_q;
		prefix_d = prefix_q;
		line_d   = line_q;
		col_d    = col_q;
		handled  = 1'b0;
		newline  = 1'b0;
		do_flush = 1'b0;
		n_res    = 2'd0;
		for (int i = 0; i < stl_pkg::MAX_RES; i++) begin
			res_c[i] = '0;
		end
		line_x  = 32'(line_q);
		// column of the dot held behind an integer
		dot_sum = {1'b0, 32'(start_q)} + 33'(tlen_q);
		dot_col = (dot_sum > COL_MAX33) ? COL_MAX33[31:0] : dot_sum[31:0];

		if (op == stl_pkg::OP_END) begin
			do_flush = 1'b1;
		end else begin
			unique case (pend_q)
				stl_pkg::P_INT: begin
					if (stl_pkg::is_digit(character)) begin
						tlen_d  = stl_pkg::sat_add16(tlen_q, 2'd1);
						handled = 1'b1;
					end else if (character == stl_pkg::CH_DOT) begin
						pend_d  = stl_pkg::P_INTDOT;
						handled = 1'b1;
					end
				end
				stl_pkg::P_INTDOT: begin
					if (stl_pkg::is_digit(character)) begin
						tlen_d  = stl_pkg::sat_add16(tlen_q, 2'd2);
						pend_d  = stl_pkg::P_FLOAT;
						handled = 1'b1;
					end
				end
				stl_pkg::P_FLOAT: begin
					if (stl_pkg::is_digit(character)) begin
						tlen_d  = stl_pkg::sat_add16(tlen_q, 2'd1);
						handled = 1'b1;
					end
				end
				stl_pkg::P_IDENT: begin
					if (stl_pkg::is_alpha_u(character) || stl_pkg::is_digit(character)) begin
						if (tlen_q < 16'd5) begin
							prefix_d = {prefix_q[31:0], character};
						end
						tlen_d  = stl_pkg::sat_add16(tlen_q, 2'd1);
						handled = 1'b1;
					end
				end
				stl_pkg::P_LT, stl_pkg::P_GT, stl_pkg::P_EQ: begin
					if (character == stl_pkg::CH_EQ) begin
						res_c[n_res] = stl_pkg::make_tok(
							(pend_q == stl_pkg::P_LT) ? stl_pkg::K_LE :
							(pend_q == stl_pkg::P_GT) ? stl_pkg::K_GE : stl_pkg::K_EQUAL,
							line_x, 32'(start_q), 16'd2);
						n_res   = n_res + 2'd1;
						pend_d  = stl_pkg::P_NONE;
						tlen_d  = '0;
						handled = 1'b1;
					end
				end
				default: ;
			endcase
			if (!handled) begin
				do_flush = 1'b1;
			end
		end

		// Close the pending token
		if (do_flush) begin
			unique case (pend_q)
				stl_pkg::P_INT: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_INT, line_x,
						32'(start_q), tlen_q);
					n_res = n_res + 2'd1;
				end
				stl_pkg::P_INTDOT: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_INT, line_x,
						32'(start_q), tlen_q);
					n_res = n_res + 2'd1;
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_UNKNOWN, line_x,
						dot_col, 16'd1);
					n_res = n_res + 2'd1;
				end
				stl_pkg::P_FLOAT: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_FLOAT, line_x,
						32'(start_q), tlen_q);
					n_res = n_res + 2'd1;
				end
				stl_pkg::P_IDENT: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::word_kind(tlen_q, prefix_q),
						line_x, 32'(start_q), tlen_q);
					n_res = n_res + 2'd1;
				end
				stl_pkg::P_LT: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_LESS, line_x,
						32'(start_q), 16'd1);
					n_res = n_res + 2'd1;
				end
				stl_pkg::P_GT: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_GREATER, line_x,
						32'(start_q), 16'd1);
					n_res = n_res + 2'd1;
				end
				stl_pkg::P_EQ: begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_ASSIGN, line_x,
						32'(start_q), 16'd1);
					n_res = n_res + 2'd1;
				end
				default: ;
			endcase
			pend_d   = stl_pkg::P_NONE;
			tlen_d   = '0;
			prefix_d = '0;
		end

		if (op == stl_pkg::OP_END) begin
			// end token, then everything back to its reset value
			res_c[n_res] = stl_pkg::make_tok(stl_pkg::K_END, line_x, 32'(col_q), 16'd0);
			n_res    = n_res + 2'd1;
			pend_d   = stl_pkg::P_NONE;
			start_d  = '0;
			tlen_d   = '0;
			prefix_d = '0;
			line_d   = '0;
			col_d    = '0;
		end else begin
			if (!handled) begin
				// byte starts fresh with nothing pending
				if (stl_pkg::is_space(character)) begin
					if (character == stl_pkg::CH_LF) begin
						newline = 1'b1;
						if (line_q != '1) begin
							line_d = line_q + LINE_BITS'(1);
						end
					end
				end else if (stl_pkg::is_digit(character)) begin
					pend_d  = stl_pkg::P_INT;
					start_d = col_q;
					tlen_d  = 16'd1;
				end else if (stl_pkg::is_alpha_u(character)) begin
					pend_d   = stl_pkg::P_IDENT;
					start_d  = col_q;
					tlen_d   = 16'd1;
					prefix_d = 40'(character);
				end else if (character == stl_pkg::CH_LT) begin
					pend_d  = stl_pkg::P_LT;
					start_d = col_q;
					tlen_d  = 16'd1;
				end else if (character == stl_pkg::CH_GT) begin
					pend_d  = stl_pkg::P_GT;
					start_d = col_q;
					tlen_d  = 16'd1;
				end else if (character == stl_pkg::CH_EQ) begin
					pend_d  = stl_pkg::P_EQ;
					start_d = col_q;
					tlen_d  = 16'd1;
				end else begin
					res_c[n_res] = stl_pkg::make_tok(stl_pkg::single_kind(character),
						line_x, 32'(col_q), 16'd1);
					n_res = n_res + 2'd1;
				end
			end
			if (newline) begin
				col_d = '0;
			end else if (col_q != '1) begin
				col_d = col_q + COLUMN_BITS'(1);
			end
		end
	end

	// Scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= stl_pkg::P_NONE;
			start_q  <= '0;
			tlen_q   <= '0;
			prefix_q <= '0;
			line_q   <= '0;
			col_q    <= '0;
		end else if (acc) begin
			pend_q   <= pend_d;
			start_q  <= start_d;
			tlen_q   <= tlen_d;
			prefix_q <= prefix_d;
			line_q   <= line_d;
			col_q    <= col_d;
		end
	end

	// Queue storage: up to three tokens written per accepted request
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < stl_pkg::MAX_RES; i++) begin
				if (2'(i) < n_res) begin
					fifo_q[wr_q + stl_pkg::PTR_W'(i)].tok  <= res_c[i];
					fifo_q[wr_q + stl_pkg::PTR_W'(i)].last <= (2'(i) == n_res - 2'd1);
				end
			end
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				wr_q <= wr_q + stl_pkg::PTR_W'(n_res);
			end
			if (pop) begin
				rd_q <= rd_q + stl_pkg::PTR_W'(1);
			end
			cnt_q <= cnt_q + (acc ? stl_pkg::CNT_W'(n_res) : '0)
				- stl_pkg::CNT_W'(pop);
		end
	end

endmodule
